[rtl/cmpt_pkg.sv]
// Package for the color matrix pixel transform.
// Holds widths, register codes, reset values and shared types.
// No dependencies; the modules of the block import it.
package cmpt_pkg;

    localparam int NUM_CH    = 4;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int X_W       = SAMPLE_W + 1;
    localparam int PROD_W    = COEF_W + X_W;
    localparam int ACC_W     = 38;
    localparam int FRAC_BITS = 14;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd8192);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_ROW   = 3'd0,
        REG_GREEN_ROW = 3'd1,
        REG_BLUE_ROW  = 3'd2,
        REG_ALPHA_ROW = 3'd3,
        REG_OFFSETS   = 3'd4,
        REG_MODE      = 3'd5
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] RED_ROW_RESET   = 64'h0000_0000_0000_1000;
    localparam logic [CFG_W-1:0] GREEN_ROW_RESET = 64'h0000_0000_1000_0000;
    localparam logic [CFG_W-1:0] BLUE_ROW_RESET  = 64'h0000_1000_0000_0000;
    localparam logic [CFG_W-1:0] ALPHA_ROW_RESET = 64'h1000_0000_0000_0000;
    localparam logic [CFG_W-1:0] OFFSETS_RESET   = 64'h0000_0000_0000_0000;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] pixel_t;

    typedef struct packed {
        logic [NUM_CH-1:0][CFG_W-1:0] row;
        logic [CFG_W-1:0]             offsets;
        logic                         four_mode;
    } cfg_t;

    typedef struct packed {
        logic load_prod;
        logic load_acc;
        logic load_out;
        logic bypass;
    } lane_ctl_t;

endpackage

[rtl/cmpt_in_if.sv]
// Input pixel channel: valid/ready handshake with the RGBA samples,
// the mask bit and the end-of-image mark. Depends on nothing.
interface cmpt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
    logic        mask_enable;
    logic        end_of_image_in;

    modport source (
        output valid, red_in, green_in, blue_in, alpha_in, mask_enable, end_of_image_in,
        input  ready
    );

    modport sink (
        input  valid, red_in, green_in, blue_in, alpha_in, mask_enable, end_of_image_in,
        output ready
    );
endinterface

[rtl/cmpt_out_if.sv]
// Result pixel channel: valid/ready handshake with the transformed
// RGBA samples and the end-of-image mark. Depends on nothing.
interface cmpt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
    logic        end_of_image_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, end_of_image_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, end_of_image_out,
        output ready
    );
endinterface

[rtl/cmpt_cfg_regs.sv]
// Configuration registers: color matrix rows, offsets and channel mode.
// Depends on cmpt_pkg.
module cmpt_cfg_regs
    import cmpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RED_ROW:   cfg_next.row[0]    = cfg_data;
                REG_GREEN_ROW: cfg_next.row[1]    = cfg_data;
                REG_BLUE_ROW:  cfg_next.row[2]    = cfg_data;
                REG_ALPHA_ROW: cfg_next.row[3]    = cfg_data;
                REG_OFFSETS:   cfg_next.offsets   = cfg_data;
                REG_MODE:      cfg_next.four_mode = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row[0]    <= RED_ROW_RESET;
            cfg_reg.row[1]    <= GREEN_ROW_RESET;
            cfg_reg.row[2]    <= BLUE_ROW_RESET;
            cfg_reg.row[3]    <= ALPHA_ROW_RESET;
            cfg_reg.offsets   <= OFFSETS_RESET;
            cfg_reg.four_mode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/cmpt_pipe_ctrl.sv]
// Pipeline control: input stage, valid bits, stall chain and the
// sideband (raw samples, mask, end-of-image) that follows each pixel.
// Depends on cmpt_pkg.
module cmpt_pipe_ctrl
    import cmpt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pixel_t                  in_pixel,
    input  logic                    in_mask,
    input  logic                    in_eoi,
    input  logic                    four_mode,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic                    out_eoi,
    output pixel_t                  x_pixel,
    output pixel_t                  raw_pixel,
    output lane_ctl_t [NUM_CH-1:0]  lane_ctl
);

    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    logic   adv1, adv2, adv3, adv4;
    pixel_t x1_reg, x1_next;
    pixel_t raw1_reg, raw2_reg, raw3_reg;
    logic   mask1_reg, mask2_reg, mask3_reg;
    logic   eoi1_reg, eoi2_reg, eoi3_reg, eoi4_reg;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        x1_next    = in_pixel;
        x1_next[3] = four_mode ? in_pixel[3] : SAMPLE_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg    <= x1_next;
            raw1_reg  <= in_pixel;
            mask1_reg <= in_mask;
            eoi1_reg  <= in_eoi;
        end
        if (adv2)
        begin
            raw2_reg  <= raw1_reg;
            mask2_reg <= mask1_reg;
            eoi2_reg  <= eoi1_reg;
        end
        if (adv3)
        begin
            raw3_reg  <= raw2_reg;
            mask3_reg <= mask2_reg;
            eoi3_reg  <= eoi2_reg;
        end
        if (adv4)
        begin
            eoi4_reg  <= eoi3_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            lane_ctl[c].load_prod = adv2;
            lane_ctl[c].load_acc  = adv3;
            lane_ctl[c].load_out  = adv4;
            lane_ctl[c].bypass    = !mask3_reg;
        end
        // In three-channel mode alpha always passes through untouched.
        lane_ctl[NUM_CH-1].bypass = !mask3_reg || !four_mode;
    end

    assign x_pixel   = x1_reg;
    assign raw_pixel = raw3_reg;
    assign out_valid = v4_reg;
    assign out_eoi   = eoi4_reg;

endmodule

[rtl/cmpt_lane.sv]
// One output channel of the matrix: products, accumulation with offset,
// then rounding, saturation and the bypass select into the output register.
// Depends on cmpt_pkg.
module cmpt_lane
    import cmpt_pkg::*;
(
    input  logic                 clk,
    input  lane_ctl_t            ctl,
    input  pixel_t               x_pixel,
    input  logic [CFG_W-1:0]     row,
    input  logic [COEF_W-1:0]    offset,
    input  sample_t              raw_sample,
    output sample_t              result
);

    logic signed [NUM_CH-1:0][PROD_W-1:0] prod_reg;
    logic signed [NUM_CH-1:0][PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]              acc_reg, acc_next;
    sample_t                              result_reg, result_next;
    logic signed [ACC_W-1:0]              sum;
    logic signed [ACC_W-1:0]              off_ext;
    sample_t                              sat;

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            prod_next[k] = signed'(row[COEF_W*k +: COEF_W])
                         * signed'({1'b0, x_pixel[k]});
        end
    end

    always_comb
    begin
        sum = ACC_W'(signed'(prod_reg[0])) + ACC_W'(signed'(prod_reg[1]))
            + ACC_W'(signed'(prod_reg[2])) + ACC_W'(signed'(prod_reg[3]));
        off_ext  = ACC_W'(signed'(offset));
        // An offset of one full scale equals 65535 samples: o * 65535 = (o << 16) - o.
        acc_next = (sum <<< 2) + (off_ext <<< SAMPLE_W) - off_ext + ROUND_BIAS;
    end

    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            sat = '0;
        end
        else if (|acc_reg[ACC_W-2:FRAC_BITS+SAMPLE_W])
        begin
            sat = SAMPLE_MAX;
        end
        else
        begin
            sat = acc_reg[FRAC_BITS +: SAMPLE_W];
        end
        result_next = ctl.bypass ? raw_sample : sat;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.load_acc)
        begin
            acc_reg <= acc_next;
        end
        if (ctl.load_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[rtl/color_matrix_pixel_transform.sv]
// Top level of the color matrix pixel transform: configuration registers,
// pipeline control and four matrix lanes.
// Depends on cmpt_pkg, cmpt_in_if, cmpt_out_if, cmpt_cfg_regs, cmpt_pipe_ctrl, cmpt_lane.
//
//   Channel  | Kind            | Payload
//   pixel    | sink, handshake | red_in, green_in, blue_in, alpha_in, mask_enable,
//            |                 | end_of_image_in
//   result   | source, handshk | red_out, green_out, blue_out, alpha_out,
//            |                 | end_of_image_out
//   cfg      | write only      | cfg_wr_en, cfg_index (3 bits), cfg_data (64 bits)
//
// One pixel per clock while the result channel does not stall; each transaction passes
// through input register, multipliers, accumulator with offset, round and saturate.
// Reset is asynchronous and clears the valid bits and loads the identity matrix.
// A result stall holds each occupied stage with no empty stage after it; empty ones fill.
module color_matrix_pixel_transform
    import cmpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cmpt_in_if.sink              pixel,
    cmpt_out_if.source           result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t                   cfg;
    pixel_t                 in_pixel;
    pixel_t                 x_pixel;
    pixel_t                 raw_pixel;
    pixel_t                 lane_result;
    lane_ctl_t [NUM_CH-1:0] lane_ctl;

    assign in_pixel[0] = pixel.red_in;
    assign in_pixel[1] = pixel.green_in;
    assign in_pixel[2] = pixel.blue_in;
    assign in_pixel[3] = pixel.alpha_in;

    cmpt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmpt_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .in_pixel  (in_pixel),
        .in_mask   (pixel.mask_enable),
        .in_eoi    (pixel.end_of_image_in),
        .four_mode (cfg.four_mode),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_eoi   (result.end_of_image_out),
        .x_pixel   (x_pixel),
        .raw_pixel (raw_pixel),
        .lane_ctl  (lane_ctl)
    );

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        cmpt_lane u_lane (
            .clk        (clk),
            .ctl        (lane_ctl[c]),
            .x_pixel    (x_pixel),
            .row        (cfg.row[c]),
            .offset     (cfg.offsets[COEF_W*c +: COEF_W]),
            .raw_sample (raw_pixel[c]),
            .result     (lane_result[c])
        );
    end

    assign result.red_out   = lane_result[0];
    assign result.green_out = lane_result[1];
    assign result.blue_out  = lane_result[2];
    assign result.alpha_out = lane_result[3];

endmodule
